// ----- sv/mfhp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhp_pkg: shared types and constants
// Start codes, frame kinds and the record that travels from the front part
// to the back part of the frame header parser.
// ----------------------------------------------------------------------------
package mfhp_pkg;

	localparam logic [7:0] CODE_I_H264  = 8'hFD;
	localparam logic [7:0] CODE_I_MPEG4 = 8'hFB;
	localparam logic [7:0] CODE_I_JPEG  = 8'hFE;
	localparam logic [7:0] CODE_P_H264  = 8'hFC;
	localparam logic [7:0] CODE_P_MPEG4 = 8'hFA;
	localparam logic [7:0] CODE_AUDIO   = 8'hF0;
	localparam logic [7:0] CODE_DATA    = 8'hF1;

	localparam logic [1:0] KIND_I     = 2'd0;
	localparam logic [1:0] KIND_P     = 2'd1;
	localparam logic [1:0] KIND_AUDIO = 2'd2;
	localparam logic [1:0] KIND_DATA  = 2'd3;

	localparam logic [7:0] AUDIO_CODE_IN  = 8'd10;
	localparam logic [7:0] AUDIO_CODE_OUT = 8'd22;
	localparam logic [7:0] DATA_TYPE_LONG = 8'd8;

	// The frame kind travels on tuser, every other field on tdata.
	localparam int OUT_BITS = 2 + 8 + 5 + 3 + 8 + 11 + 11 + 32 + 32 + 8 + 1;
	localparam int KIND_BITS = 2;
	localparam int DATA_BITS = OUT_BITS - KIND_BITS;
	localparam int OUT_BYTES_BITS = ((DATA_BITS + 7) / 8) * 8;

	// Complete header as collected by the front part.
	typedef struct packed {
		logic [1:0]      kind;
		logic [1:0]      codec;
		logic [11:0][7:0] hdr;
	} hdr_rec_t;

	// Decoded result record.
	typedef struct packed {
		logic        frame_usable;
		logic [7:0]  audio_rate_code;
		logic [31:0] frame_length;
		logic [31:0] packed_time;
		logic [10:0] pixel_height;
		logic [10:0] pixel_width;
		logic [7:0]  stream_param_byte;
		logic [2:0]  stream_param_hi;
		logic [4:0]  frame_rate;
		logic [7:0]  codec;
		logic [1:0]  frame_kind;
	} out_rec_t;

endpackage

// ----- sv/mfhp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhp_front: start code hunt and header collection
// Takes one byte a cycle unless stalled, finds start codes, gathers the header
// bytes and hands a complete header to the queue. The payload skip count needs
// the length, which is computed here too so that skipping starts at once.
// ----------------------------------------------------------------------------
module mfhp_front import mfhp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       hdr_valid,
	input  logic       hdr_ready,
	output hdr_rec_t   hdr_rec
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0]       phase_q;
	logic [1:0]       pos_q;
	logic [3:0]       cnt_q;
	logic [7:0]       code_q;
	logic [11:0][7:0] hdr_q;
	logic [31:0]      left_q;
	logic [11:0][7:0] hdr_n;
	logic             last_byte;
	logic             take;
	logic [31:0]      len;
	logic [1:0]       kind;
	logic [1:0]       codec;

	assign take = in_valid && in_ready;

	// Stall only when a header completes and the queue is full.
	assign in_ready = !(phase_q == PH_HEADER && last_byte && !hdr_ready);

	// Header with the incoming byte placed.
	always_comb begin
		hdr_n = hdr_q;
		hdr_n[cnt_q] = in_byte;
	end

	// Classify the start code.
	always_comb begin
		kind  = KIND_DATA;
		codec = 2'd0;
		case (code_q)
			CODE_I_H264:  begin kind = KIND_I; codec = 2'd0; end
			CODE_I_MPEG4: begin kind = KIND_I; codec = 2'd1; end
			CODE_I_JPEG:  begin kind = KIND_I; codec = 2'd2; end
			CODE_P_H264:  begin kind = KIND_P; codec = 2'd0; end
			CODE_P_MPEG4: begin kind = KIND_P; codec = 2'd1; end
			CODE_AUDIO:   kind = KIND_AUDIO;
			default:      kind = KIND_DATA;
		endcase
	end

	// Header end; a data frame header is long only when byte zero holds the long type.
	always_comb begin
		case (kind)
			KIND_I:    last_byte = (cnt_q == 4'd11);
			KIND_DATA: last_byte = (cnt_q == 4'd11) ||
				(cnt_q == 4'd3 && hdr_n[0] != DATA_TYPE_LONG);
			default:   last_byte = (cnt_q == 4'd3);
		endcase
	end

	// Payload length; a P frame loses one byte on a sequence gap, saturating
	// at zero, so the skip count and the record carry the adjusted value.
	logic [7:0]  prev_q;
	logic [7:0]  prev_eff;
	logic        gap;
	always_comb begin
		prev_eff = (prev_q == 8'd0) ? hdr_n[3] : prev_q;
		gap = ((hdr_n[3] > prev_eff && hdr_n[3] != prev_eff + 8'd1) ||
			hdr_n[3] < prev_eff) && !(hdr_n[3] == 8'd0 && prev_eff == 8'hFF);
		if (prev_eff == 8'hFF && hdr_n[3] == 8'd0) gap = 1'b0;
		case (kind)
			KIND_I:     len = {8'd0, hdr_n[10], hdr_n[9], hdr_n[8]};
			KIND_P: begin
				len = {8'd0, hdr_n[2], hdr_n[1], hdr_n[0]};
				if (gap && len != 32'd0) len = len - 32'd1;
			end
			KIND_AUDIO: len = {16'd0, hdr_n[3], hdr_n[2]};
			default:    len = (hdr_n[0] == DATA_TYPE_LONG) ?
				{hdr_n[11], hdr_n[10], hdr_n[9], hdr_n[8]} : 32'd4;
		endcase
	end

	// Sequencing of hunt, header and payload skip.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= 2'd0;
			cnt_q   <= 4'd0;
			code_q  <= 8'd0;
			left_q  <= 32'd0;
			prev_q  <= 8'd0;
		end else if (take) begin
			case (phase_q)
				PH_HUNT: begin
					case (pos_q)
						2'd0, 2'd1: pos_q <= (in_byte == 8'h00) ? pos_q + 2'd1 : 2'd0;
						2'd2: pos_q <= (in_byte == 8'h01) ? 2'd3 : 2'd0;
						default: begin
							pos_q <= 2'd0;
							if (in_byte inside {CODE_I_H264, CODE_I_MPEG4, CODE_I_JPEG,
								CODE_P_H264, CODE_P_MPEG4, CODE_AUDIO, CODE_DATA}) begin
								code_q  <= in_byte;
								cnt_q   <= 4'd0;
								phase_q <= PH_HEADER;
							end
						end
					endcase
				end
				PH_HEADER: begin
					cnt_q <= cnt_q + 4'd1;
					if (last_byte) begin
						cnt_q   <= 4'd0;
						left_q  <= len;
						phase_q <= (len == 32'd0) ? PH_HUNT : PH_PAYLOAD;
						if (kind == KIND_I) prev_q <= hdr_n[11];
						else if (kind == KIND_P) prev_q <= hdr_n[3];
					end
				end
				default: begin
					left_q <= left_q - 32'd1;
					if (left_q == 32'd1) phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// Header storage.
	always_ff @(posedge clk) begin
		if (take && phase_q == PH_HEADER) hdr_q <= hdr_n;
	end

	assign hdr_valid     = in_valid && phase_q == PH_HEADER && last_byte;
	assign hdr_rec.kind  = kind;
	assign hdr_rec.codec = codec;
	always_comb begin
		hdr_rec.hdr = hdr_n;
		// P frame length already carries the sequence adjustment.
		if (kind == KIND_P) hdr_rec.hdr[2:0] = len[23:0];
	end

endmodule

// ----- sv/mfhp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhp_queue: header queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module mfhp_queue import mfhp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  hdr_rec_t wr_rec,
	output logic     rd_valid,
	input  logic     rd_ready,
	output hdr_rec_t rd_rec
);

	hdr_rec_t mem_q [2];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_rec   = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_rec;
	end

endmodule

// ----- sv/mfhp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfhp_back: record decode
// Decodes a queued header into the result record held in an output register.
// ----------------------------------------------------------------------------
module mfhp_back import mfhp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     hdr_valid,
	output logic     hdr_ready,
	input  hdr_rec_t hdr_rec,
	output logic     out_valid,
	input  logic     out_ready,
	output out_rec_t out_rec
);

	out_rec_t r;
	logic     valid_q;
	out_rec_t rec_q;

	// Field decode by frame kind.
	always_comb begin
		r = '0;
		r.frame_kind   = hdr_rec.kind;
		r.frame_usable = 1'b1;
		case (hdr_rec.kind)
			KIND_I: begin
				r.codec             = {6'd0, hdr_rec.codec};
				r.frame_rate        = hdr_rec.hdr[1][4:0];
				r.stream_param_hi   = hdr_rec.hdr[1][7:5];
				r.stream_param_byte = hdr_rec.hdr[0];
				r.pixel_width       = {hdr_rec.hdr[2], 3'd0};
				r.pixel_height      = {hdr_rec.hdr[3], 3'd0};
				r.packed_time = {hdr_rec.hdr[7], hdr_rec.hdr[6], hdr_rec.hdr[5],
					hdr_rec.hdr[4]};
				r.frame_length = {8'd0, hdr_rec.hdr[10], hdr_rec.hdr[9], hdr_rec.hdr[8]};
			end
			KIND_P: begin
				r.codec        = {6'd0, hdr_rec.codec};
				r.frame_length = {8'd0, hdr_rec.hdr[2], hdr_rec.hdr[1], hdr_rec.hdr[0]};
			end
			KIND_AUDIO: begin
				r.codec = (hdr_rec.hdr[0] == AUDIO_CODE_IN) ? AUDIO_CODE_OUT :
					hdr_rec.hdr[0];
				r.audio_rate_code = hdr_rec.hdr[1];
				r.frame_length    = {16'd0, hdr_rec.hdr[3], hdr_rec.hdr[2]};
			end
			default: begin
				if (hdr_rec.hdr[0] == DATA_TYPE_LONG) begin
					r.frame_length = {hdr_rec.hdr[11], hdr_rec.hdr[10], hdr_rec.hdr[9],
						hdr_rec.hdr[8]};
				end else begin
					r.frame_length = 32'd4;
					r.frame_usable = 1'b0;
				end
			end
		endcase
	end

	assign hdr_ready = !valid_q || out_ready;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (hdr_ready) valid_q <= hdr_valid;
	end

	always_ff @(posedge clk) begin
		if (hdr_ready && hdr_valid) rec_q <= r;
	end

	assign out_valid = valid_q;
	assign out_rec   = rec_q;

endmodule

// ----- sv/media_frame_header_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// media_frame_header_parser: media frame header parser
// Hunts start codes in a byte stream and emits one record per frame header.
// ----------------------------------------------------------------------------
// One byte is taken every cycle unless the front part stalls. A record passes
// through a queue entry and then the output register; the front part keeps
// taking bytes while up to three records wait, two in the queue and one in the
// output register, and stalls only when the queue is full as a header
// completes. Payload bytes are skipped at one a cycle.
module media_frame_header_parser import mfhp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata, // data_byte
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// codec, frame_rate, stream_param_hi, stream_param_byte, pixel_width,
	// pixel_height, packed_time, frame_length, audio_rate_code, frame_usable
	output logic [OUT_BYTES_BITS-1:0] m_tdata,
	output logic [KIND_BITS-1:0]      m_tuser // frame_kind
);

	hdr_rec_t f_rec, b_rec;
	logic     f_valid, f_ready, b_valid, b_ready;
	out_rec_t o_rec;

	mfhp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
		.hdr_valid(f_valid), .hdr_ready(f_ready), .hdr_rec(f_rec)
	);

	mfhp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_rec(f_rec),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_rec(b_rec)
	);

	mfhp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.hdr_valid(b_valid), .hdr_ready(b_ready), .hdr_rec(b_rec),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_rec(o_rec)
	);

	assign m_tdata = {{(OUT_BYTES_BITS - DATA_BITS){1'b0}}, o_rec[OUT_BITS-1:KIND_BITS]};
	assign m_tuser = o_rec.frame_kind;

endmodule
